// ===== src/tfp_pkg.sv =====
// Shared types and constants for the telemetry frame parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tfp_pkg;

  localparam logic [7:0] SYNC_BYTE      = 8'hFF;
  localparam logic [7:0] TYPE_VOLTS     = 8'hFE;
  localparam logic [7:0] TYPE_USER      = 8'hFD;
  localparam logic [7:0] TYPE_ALARM_HI  = 8'hFC;
  localparam logic [7:0] TYPE_ALARM_LO  = 8'hF9;

  localparam logic [1:0] KIND_VOLTS     = 2'd0;
  localparam logic [1:0] KIND_THRESHOLD = 2'd1;
  localparam logic [1:0] KIND_USER      = 2'd2;

  localparam int unsigned TDATA_W = 64;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] volt_first;
    logic [7:0] volt_second;
    logic [7:0] link_quality;
    logic [1:0] alarm_channel;
    logic [7:0] alarm_level;
    logic [7:0] alarm_greater;
    logic [7:0] alarm_setting;
    logic [7:0] user_byte;
    logic       user_last;
  } result_t;

endpackage

// ===== src/tfp_in_stage.sv =====
// Input register of the telemetry frame parser: holds one received byte.
// Depends on tfp_pkg.
`timescale 1ns / 1ps

module tfp_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       take,
  output logic       byte_valid,
  output logic [7:0] byte_data
);
  import tfp_pkg::*;

  logic       valid_r;
  logic [7:0] data_r;

  assign in_tready  = !valid_r || take;
  assign byte_valid = valid_r;
  assign byte_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      data_r <= in_tdata;
    end
  end

endmodule

// ===== src/tfp_parser.sv =====
// Frame phase machine and held frame bytes; decodes one byte per step.
// Depends on tfp_pkg.
`timescale 1ns / 1ps

module tfp_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_valid,
  input  logic [7:0]        byte_data,
  input  logic              out_free,
  output logic              take,
  output logic              push,
  output tfp_pkg::result_t  result
);
  import tfp_pkg::*;

  localparam logic [3:0] PH_HUNT    = 4'd0;
  localparam logic [3:0] PH_TYPE    = 4'd1;
  localparam logic [3:0] PH_LEVEL   = 4'd2;
  localparam logic [3:0] PH_GREATER = 4'd3;
  localparam logic [3:0] PH_ALARM   = 4'd4;
  localparam logic [3:0] PH_VOLT1   = 4'd5;
  localparam logic [3:0] PH_VOLT2   = 4'd6;
  localparam logic [3:0] PH_LINK    = 4'd7;
  localparam logic [3:0] PH_LENGTH  = 4'd8;
  localparam logic [3:0] PH_SERIAL  = 4'd9;
  localparam logic [3:0] PH_DATA    = 4'd10;

  logic [3:0] phase_r, phase_nxt;
  logic [1:0] channel_r, channel_nxt;
  logic [7:0] level_r, level_nxt;
  logic [7:0] greater_r, greater_nxt;
  logic [7:0] volt1_r, volt1_nxt;
  logic [7:0] volt2_r, volt2_nxt;
  logic [7:0] length_r, length_nxt;
  logic [7:0] taken_r, taken_nxt;
  logic [7:0] chan_diff;
  logic [7:0] taken_inc;
  logic       has_result;

  assign chan_diff = TYPE_ALARM_HI - byte_data;
  assign taken_inc = taken_r + 8'd1;

  always_comb begin
    phase_nxt   = phase_r;
    channel_nxt = channel_r;
    level_nxt   = level_r;
    greater_nxt = greater_r;
    volt1_nxt   = volt1_r;
    volt2_nxt   = volt2_r;
    length_nxt  = length_r;
    taken_nxt   = taken_r;
    has_result  = 1'b0;
    result      = '0;
    unique case (phase_r)
      PH_TYPE: begin
        if (byte_data == TYPE_VOLTS) begin
          phase_nxt = PH_VOLT1;
        end else if (byte_data == TYPE_USER) begin
          phase_nxt = PH_LENGTH;
        end else if (byte_data >= TYPE_ALARM_LO && byte_data <= TYPE_ALARM_HI) begin
          channel_nxt = chan_diff[1:0];
          phase_nxt   = PH_LEVEL;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_LEVEL: begin
        level_nxt = byte_data;
        phase_nxt = PH_GREATER;
      end
      PH_GREATER: begin
        greater_nxt = byte_data;
        phase_nxt   = PH_ALARM;
      end
      PH_ALARM: begin
        has_result           = 1'b1;
        result.result_kind   = KIND_THRESHOLD;
        result.alarm_channel = channel_r;
        result.alarm_level   = level_r;
        result.alarm_greater = greater_r;
        result.alarm_setting = byte_data;
        phase_nxt            = PH_HUNT;
      end
      PH_VOLT1: begin
        volt1_nxt = byte_data;
        phase_nxt = PH_VOLT2;
      end
      PH_VOLT2: begin
        volt2_nxt = byte_data;
        phase_nxt = PH_LINK;
      end
      PH_LINK: begin
        has_result          = 1'b1;
        result.result_kind  = KIND_VOLTS;
        result.volt_first   = volt1_r;
        result.volt_second  = volt2_r;
        result.link_quality = byte_data;
        phase_nxt           = PH_HUNT;
      end
      PH_LENGTH: begin
        length_nxt = byte_data;
        phase_nxt  = PH_SERIAL;
      end
      PH_SERIAL: begin
        taken_nxt = 8'd0;
        phase_nxt = (length_r == 8'd0) ? PH_HUNT : PH_DATA;
      end
      PH_DATA: begin
        has_result         = 1'b1;
        taken_nxt          = taken_inc;
        result.result_kind = KIND_USER;
        result.user_byte   = byte_data;
        if (taken_inc == length_r) begin
          result.user_last = 1'b1;
          phase_nxt        = PH_HUNT;
        end
      end
      default: begin
        phase_nxt = (byte_data == SYNC_BYTE) ? PH_TYPE : PH_HUNT;
      end
    endcase
  end

  assign take = byte_valid && (!has_result || out_free);
  assign push = take && has_result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HUNT;
      channel_r <= 2'd0;
      level_r   <= 8'd0;
      greater_r <= 8'd0;
      volt1_r   <= 8'd0;
      volt2_r   <= 8'd0;
      length_r  <= 8'd0;
      taken_r   <= 8'd0;
    end else if (take) begin
      phase_r   <= phase_nxt;
      channel_r <= channel_nxt;
      level_r   <= level_nxt;
      greater_r <= greater_nxt;
      volt1_r   <= volt1_nxt;
      volt2_r   <= volt2_nxt;
      length_r  <= length_nxt;
      taken_r   <= taken_nxt;
    end
  end

endmodule

// ===== src/tfp_out_stage.sv =====
// Result register of the telemetry frame parser: holds one result for the stream.
// Depends on tfp_pkg.
`timescale 1ns / 1ps

module tfp_out_stage (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  tfp_pkg::result_t             result,
  output logic                         out_free,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [tfp_pkg::TDATA_W-1:0]  out_tdata,
  output logic [1:0]                   out_tuser,
  output logic                         out_tlast
);
  import tfp_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign out_free   = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tuser  = res_r.result_kind;
  assign out_tlast  = res_r.user_last;
  assign out_tdata  = {6'd0, res_r.user_byte, res_r.alarm_setting, res_r.alarm_greater,
                       res_r.alarm_level, res_r.alarm_channel, res_r.link_quality,
                       res_r.volt_second, res_r.volt_first};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_r <= result;
    end
  end

endmodule

// ===== src/telemetry_frame_parser_unit.sv =====
// Telemetry frame parser: sync hunt, frame decode and result streaming.
// Depends on tfp_pkg, tfp_in_stage, tfp_parser and tfp_out_stage.
// Usage:
//   The in_ channel carries one received serial byte per request. The parser
//   hunts for the sync byte, decodes the type byte and collects volts,
//   threshold and user data frames. The out_ channel carries one result per
//   request: a whole volts or threshold frame, or a single user data byte,
//   with tlast set on the final byte of a user data frame.
//   Throughput is one byte per cycle while the receiver takes results. A byte
//   is held in the input register and decoded there; when it is taken, its
//   result loads into the result register, which raises out_tvalid. Bytes
//   that neither close a frame nor carry user data produce no result.
//   The result register decouples the two sides: a new byte is taken while a
//   result waits, as long as that byte yields no result or the waiting one
//   leaves in the same cycle. When the receiver stalls with a result held,
//   the next result-bearing byte holds in the input register and in_tready
//   drops until out_tready returns.
//   Synchronous active-low reset empties both registers and returns the
//   parser to hunting with all held frame bytes cleared.
`timescale 1ns / 1ps

module telemetry_frame_parser_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] rx_byte
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [7:0] volt_first, [15:8] volt_second, [23:16] link_quality,
  // [25:24] alarm_channel, [33:26] alarm_level, [41:34] alarm_greater,
  // [49:42] alarm_setting, [57:50] user_byte, [63:58] zero
  output logic [tfp_pkg::TDATA_W-1:0]  out_tdata,
  output logic [1:0]                   out_tuser,  // [1:0] result_kind
  output logic                         out_tlast   // user_last
);
  import tfp_pkg::*;

  logic       byte_valid;
  logic [7:0] byte_data;
  logic       take;
  logic       push;
  logic       out_free;
  result_t    result;

  tfp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .take       (take),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  tfp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .out_free   (out_free),
    .take       (take),
    .push       (push),
    .result     (result)
  );

  tfp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .result     (result),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== test/telemetry_frame_parser_unit_tb.sv =====
// Testbench for telemetry_frame_parser_unit: directed and random byte streams,
// with a bit-exact parse model in the bench and random stalls on both streams.
// Depends on tfp_pkg and the telemetry_frame_parser_unit RTL.
`timescale 1ns / 1ps

module telemetry_frame_parser_unit_tb;
  import tfp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned TOTAL_BYTES = 1400;
  localparam int unsigned MAX_REPORTS = 10;

  typedef enum logic [3:0] {
    SEEK_SYNC, GET_TYPE, GET_LEVEL, GET_GREATER, GET_ALARM,
    GET_VOLT1, GET_VOLT2, GET_LINK, GET_LENGTH, GET_SERIAL, GET_DATA
  } parse_phase_e;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata = 8'h00;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [TDATA_W-1:0]   out_tdata;
  logic [1:0]           out_tuser;
  logic                 out_tlast;

  parse_phase_e rx_phase = SEEK_SYNC;
  logic [1:0]   thr_channel = '0;
  logic [7:0]   thr_level = '0;
  logic [7:0]   thr_greater = '0;
  logic [7:0]   volt_a = '0;
  logic [7:0]   volt_b = '0;
  logic [7:0]   user_len = '0;
  logic [7:0]   user_count = '0;

  result_t      due_results[$];
  int unsigned  bytes_sent = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;
  int unsigned  hold_request = 0;
  bit           steady_input = 1'b0;
  bit           steady_output = 1'b0;

  telemetry_frame_parser_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("telemetry_frame_parser_unit test failed");
      $finish;
    end
  end

  task automatic parse_rx_byte(input logic [7:0] b);
    result_t    res;
    logic [7:0] chan_diff;
    res = '0;
    case (rx_phase)
      GET_TYPE: begin
        if (b == TYPE_VOLTS) begin
          rx_phase = GET_VOLT1;
        end else if (b == TYPE_USER) begin
          rx_phase = GET_LENGTH;
        end else if (b >= TYPE_ALARM_LO && b <= TYPE_ALARM_HI) begin
          chan_diff = TYPE_ALARM_HI - b;
          thr_channel = chan_diff[1:0];
          rx_phase = GET_LEVEL;
        end else begin
          rx_phase = SEEK_SYNC;
        end
      end
      GET_LEVEL: begin
        thr_level = b;
        rx_phase = GET_GREATER;
      end
      GET_GREATER: begin
        thr_greater = b;
        rx_phase = GET_ALARM;
      end
      GET_ALARM: begin
        res.result_kind = KIND_THRESHOLD;
        res.alarm_channel = thr_channel;
        res.alarm_level = thr_level;
        res.alarm_greater = thr_greater;
        res.alarm_setting = b;
        due_results.push_back(res);
        rx_phase = SEEK_SYNC;
      end
      GET_VOLT1: begin
        volt_a = b;
        rx_phase = GET_VOLT2;
      end
      GET_VOLT2: begin
        volt_b = b;
        rx_phase = GET_LINK;
      end
      GET_LINK: begin
        res.result_kind = KIND_VOLTS;
        res.volt_first = volt_a;
        res.volt_second = volt_b;
        res.link_quality = b;
        due_results.push_back(res);
        rx_phase = SEEK_SYNC;
      end
      GET_LENGTH: begin
        user_len = b;
        rx_phase = GET_SERIAL;
      end
      GET_SERIAL: begin
        user_count = '0;
        rx_phase = (user_len == 8'd0) ? SEEK_SYNC : GET_DATA;
      end
      GET_DATA: begin
        user_count = user_count + 8'd1;
        res.result_kind = KIND_USER;
        res.user_byte = b;
        if (user_count == user_len) begin
          res.user_last = 1'b1;
          rx_phase = SEEK_SYNC;
        end
        due_results.push_back(res);
      end
      default: begin
        rx_phase = (b == SYNC_BYTE) ? GET_TYPE : SEEK_SYNC;
      end
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = steady_input ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    parse_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("mismatch in %s at cycle %0d: expected %h, got %h",
               what, cycle_count, want, got);
    end
  endtask

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      flag_mismatch(what, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_results.size() == 0) begin
        flag_mismatch("unexpected result", '0, out_tdata);
      end else begin
        want = due_results.pop_front();
        check_field("result_kind", want.result_kind, out_tuser);
        check_field("volt_first", want.volt_first, out_tdata[7:0]);
        check_field("volt_second", want.volt_second, out_tdata[15:8]);
        check_field("link_quality", want.link_quality, out_tdata[23:16]);
        check_field("alarm_channel", want.alarm_channel, out_tdata[25:24]);
        check_field("alarm_level", want.alarm_level, out_tdata[33:26]);
        check_field("alarm_greater", want.alarm_greater, out_tdata[41:34]);
        check_field("alarm_setting", want.alarm_setting, out_tdata[49:42]);
        check_field("user_byte", want.user_byte, out_tdata[57:50]);
        check_field("user_last", want.user_last, out_tlast);
        check_field("tdata padding", '0, out_tdata[63:58]);
      end
    end
  end

  initial begin : result_sink
    int unsigned stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_request > 0) begin
        out_tready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end
      stall = steady_output ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready) && hold_request == 0);
    end
  end

  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 3) == 0) begin
      return 8'($urandom_range(8'hF8, 8'hFF));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_user_frame(input int unsigned len);
    send_byte(SYNC_BYTE);
    send_byte(TYPE_USER);
    send_byte(8'(len));
    send_byte(pick_byte());
    repeat (len) send_byte(pick_byte());
  endtask

  task automatic send_random_frame();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 9);
    if (pick < 8) begin
      case ($urandom_range(0, 2))
        0: begin
          send_byte(SYNC_BYTE);
          send_byte(TYPE_VOLTS);
          repeat (3) send_byte(pick_byte());
        end
        1: begin
          send_byte(SYNC_BYTE);
          send_byte(TYPE_ALARM_HI - 8'($urandom_range(0, 3)));
          repeat (3) send_byte(pick_byte());
        end
        default: begin
          len = ($urandom_range(0, 39) == 0) ? $urandom_range(7, 255)
                                              : $urandom_range(0, 6);
          send_user_frame(len);
        end
      endcase
    end else if (pick == 8) begin
      repeat ($urandom_range(1, 6)) send_byte(pick_byte());
    end else begin
      send_byte(SYNC_BYTE);
      send_byte(pick_byte());
      repeat ($urandom_range(0, 3)) send_byte(pick_byte());
    end
  endtask

  task automatic test_volts_frame();
    send_byte(SYNC_BYTE);
    send_byte(TYPE_VOLTS);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hAA);
  endtask

  task automatic test_threshold_frame();
    send_byte(SYNC_BYTE);
    send_byte(TYPE_ALARM_LO);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h55);
  endtask

  task automatic test_user_frame();
    send_byte(SYNC_BYTE);
    send_byte(TYPE_USER);
    send_byte(8'd2);
    send_byte(8'h33);
    send_byte(SYNC_BYTE);
    send_byte(8'h00);
  endtask

  task automatic test_zero_length();
    send_byte(SYNC_BYTE);
    send_byte(TYPE_USER);
    send_byte(8'd0);
    send_byte(8'h77);
  endtask

  task automatic test_unknown_type();
    send_byte(SYNC_BYTE);
    send_byte(SYNC_BYTE);
    send_byte(TYPE_VOLTS);
    send_byte(8'h01);
    send_byte(8'h02);
    send_byte(8'h03);
  endtask

  task automatic test_backpressure();
    steady_input = 1'b1;
    hold_request = 150;
    send_user_frame(40);
    repeat (4) begin
      send_byte(SYNC_BYTE);
      send_byte(TYPE_ALARM_HI);
      repeat (3) send_byte(pick_byte());
    end
    steady_input = 1'b0;
  endtask

  task automatic test_random_traffic();
    int unsigned frames;
    frames = 0;
    while (bytes_sent < TOTAL_BYTES) begin
      if (frames % 20 == 0) begin
        steady_input = ($urandom_range(0, 3) == 0);
        steady_output = ($urandom_range(0, 3) == 0);
      end
      send_random_frame();
      frames++;
    end
    steady_input = 1'b0;
    steady_output = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_volts_frame();
    test_threshold_frame();
    test_user_frame();
    test_zero_length();
    test_unknown_type();
    test_backpressure();
    test_random_traffic();
    in_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("telemetry_frame_parser_unit test passed");
    end else begin
      $display("telemetry_frame_parser_unit test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/tfp_pkg.sv
src/tfp_in_stage.sv
src/tfp_parser.sv
src/tfp_out_stage.sv
src/telemetry_frame_parser_unit.sv
test/telemetry_frame_parser_unit_tb.sv
